>>> rtl/bls_pkg.sv
// Shared constants, command type and op codes for the line stepper.
package bls_pkg;

  localparam int COORD_BITS = 12;
  localparam int COLOR_BITS = 8;
  // Error term spans about -2*2^COORD_BITS .. +2*2^COORD_BITS: sign plus two extra bits.
  localparam int ERR_BITS   = COORD_BITS + 3;
  // Command queue depth, a power of two.
  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam int IN_DATA_BITS  = ((4 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;
  localparam int OUT_DATA_BITS = ((2 * COORD_BITS + COLOR_BITS + 7) / 8) * 8;

  localparam logic OP_LOAD = 1'b0;
  localparam logic OP_STEP = 1'b1;

  // One decoded word headed for the back end.
  typedef struct packed {
    logic                       is_load;
    logic [COORD_BITS-1:0]      x;
    logic [COORD_BITS-1:0]      y;
    logic [1:0]                 step_x;     // -1, 0 or +1, two's complement
    logic [1:0]                 step_y;
    logic                       y_major;
    logic [COORD_BITS-1:0]      major_len;
    logic [ERR_BITS-1:0]        err_minor;  // 2*minor
    logic [ERR_BITS-1:0]        err_both;   // 2*(minor-major), also the initial error
    logic [COLOR_BITS-1:0]      color;
  } bls_cmd_t;

endpackage

>>> rtl/bls_front.sv
// Front end: unpack an input word, classify it, and work out the line setup.
module bls_front import bls_pkg::*; (
  input  logic                    op,
  input  logic [IN_DATA_BITS-1:0] data,
  output bls_cmd_t                cmd
);

  logic [COORD_BITS-1:0] sx, sy, ex, ey;
  logic [COORD_BITS:0]   dx, dy;
  logic [COORD_BITS-1:0] adx, ady, major, minor;
  logic                  ymaj;

  always_comb begin
    sx = data[COORD_BITS-1:0];
    sy = data[2*COORD_BITS-1:COORD_BITS];
    ex = data[3*COORD_BITS-1:2*COORD_BITS];
    ey = data[4*COORD_BITS-1:3*COORD_BITS];
    dx = {1'b0, ex} - {1'b0, sx};
    dy = {1'b0, ey} - {1'b0, sy};
    adx = dx[COORD_BITS] ? COORD_BITS'(-dx) : dx[COORD_BITS-1:0];
    ady = dy[COORD_BITS] ? COORD_BITS'(-dy) : dy[COORD_BITS-1:0];
    ymaj  = ady > adx;
    major = ymaj ? ady : adx;
    minor = ymaj ? adx : ady;

    cmd.is_load   = (op == OP_LOAD);
    cmd.x         = sx;
    cmd.y         = sy;
    cmd.step_x    = dx[COORD_BITS] ? 2'b11 : ((dx != '0) ? 2'b01 : 2'b00);
    cmd.step_y    = dy[COORD_BITS] ? 2'b11 : ((dy != '0) ? 2'b01 : 2'b00);
    cmd.y_major   = ymaj;
    cmd.major_len = major;
    cmd.err_minor = ERR_BITS'({minor, 1'b0});
    cmd.err_both  = ERR_BITS'({minor, 1'b0}) - ERR_BITS'({major, 1'b0});
    cmd.color     = data[4*COORD_BITS+COLOR_BITS-1:4*COORD_BITS];
  end

endmodule

>>> rtl/bls_fifo.sv
// Short command queue between the front and back ends.
module bls_fifo import bls_pkg::*; (
  input  logic     clk,
  input  logic     rst,
  input  logic     push,
  input  bls_cmd_t push_data,
  output logic     in_ready,
  input  logic     pop,
  output logic     out_valid,
  output bls_cmd_t out_data
);

  bls_cmd_t             mem [FIFO_DEPTH];
  logic [FIFO_AW-1:0]   wr_ptr, rd_ptr;
  logic [FIFO_CW-1:0]   count;
  logic                 do_push, do_pop;

  assign in_ready  = (count != FIFO_CW'(FIFO_DEPTH));
  assign out_valid = (count != '0);
  assign out_data  = mem[rd_ptr];
  assign do_push   = push && in_ready;
  assign do_pop    = pop && out_valid;

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    count <= FIFO_CW'(FIFO_DEPTH))
    else $error("command queue count past depth");

  a_pop_drains: assert property (@(posedge clk) disable iff (rst)
    (do_pop && !do_push) |=> (count == $past(count) - 1'b1))
    else $error("command queue count did not drop on pop");

  a_ptr_gap: assert property (@(posedge clk) disable iff (rst)
    (count != FIFO_CW'(FIFO_DEPTH)) |-> (FIFO_AW'(count) == FIFO_AW'(wr_ptr - rd_ptr)))
    else $error("command queue pointers disagree with count");

endmodule

>>> rtl/bls_back.sv
// Back end: hold the active line, step it one pixel per step word, register the result.
module bls_back import bls_pkg::*; (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  cmd_valid,
  input  bls_cmd_t              cmd,
  output logic                  cmd_pop,
  output logic                  out_valid,
  input  logic                  out_ready,
  output logic [COORD_BITS-1:0] out_x,
  output logic [COORD_BITS-1:0] out_y,
  output logic [COLOR_BITS-1:0] out_color,
  output logic                  out_last
);

  logic [COORD_BITS-1:0] cur_x, cur_y, left;
  logic [1:0]            step_x, step_y;
  logic                  y_major, active;
  logic [ERR_BITS-1:0]   err, err_minor, err_both;
  logic [COLOR_BITS-1:0] color;

  logic                  emit, err_ok;
  logic [COORD_BITS-1:0] x_inc, y_inc, x_next, y_next;
  logic [ERR_BITS-1:0]   err_next;

  // A load never needs the output slot; a step on an idle line is dropped.
  assign cmd_pop = cmd_valid && (cmd.is_load || !active || !out_valid || out_ready);
  assign emit    = cmd_pop && !cmd.is_load && active;

  always_comb begin
    err_ok   = !err[ERR_BITS-1];
    x_inc    = cur_x + {{(COORD_BITS-2){step_x[1]}}, step_x};
    y_inc    = cur_y + {{(COORD_BITS-2){step_y[1]}}, step_y};
    x_next   = (!y_major || err_ok) ? x_inc : cur_x;
    y_next   = (y_major || err_ok) ? y_inc : cur_y;
    err_next = err + (err_ok ? err_both : err_minor);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cur_x     <= '0;
      cur_y     <= '0;
      step_x    <= '0;
      step_y    <= '0;
      y_major   <= 1'b0;
      active    <= 1'b0;
      left      <= '0;
      err       <= '0;
      err_minor <= '0;
      err_both  <= '0;
      color     <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cmd_pop && cmd.is_load) begin
        cur_x     <= cmd.x;
        cur_y     <= cmd.y;
        step_x    <= cmd.step_x;
        step_y    <= cmd.step_y;
        y_major   <= cmd.y_major;
        left      <= cmd.major_len;
        active    <= (cmd.major_len != '0);
        err       <= cmd.err_both;
        err_minor <= cmd.err_minor;
        err_both  <= cmd.err_both;
        color     <= cmd.color;
      end else if (emit) begin
        cur_x  <= x_next;
        cur_y  <= y_next;
        err    <= err_next;
        left   <= left - 1'b1;
        active <= (left != COORD_BITS'(1));
      end
      if (emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_x     <= cur_x;
      out_y     <= cur_y;
      out_color <= color;
      out_last  <= (left == COORD_BITS'(1));
    end
  end

  a_active_has_pixels: assert property (@(posedge clk) disable iff (rst)
    active |-> (left != '0))
    else $error("active line with no pixels left");

  a_last_ends_line: assert property (@(posedge clk) disable iff (rst)
    (emit && left == COORD_BITS'(1)) |=> (!active && out_valid && out_last))
    else $error("line did not end after its last pixel");

  a_step_codes: assert property (@(posedge clk) disable iff (rst)
    (step_x != 2'b10) && (step_y != 2'b10))
    else $error("step sign out of range");

endmodule

>>> rtl/bresenham_line_stepper_unit.sv
// Top level of the line stepper: front end, command queue, back end and stream ports.
// Path: a step word is written into the queue, then the back end registers its pixel on m_axis;
//   queued words ahead of it and a stalled pixel sink hold the pixel back.
// Throughput: one word per cycle on both sides while the queue has room and the sink is ready;
//   the back end holds the line state and adds one error increment per pixel.
// Reset: synchronous, active high; empties the queue and output register, line goes idle.
// A four-entry queue lets input keep flowing while the output is stalled.
module bresenham_line_stepper_unit import bls_pkg::*; (
  input  logic                     clk,
  input  logic                     rst,
  // Input stream.
  input  logic                     s_axis_tvalid,
  output logic                     s_axis_tready,
  input  logic [IN_DATA_BITS-1:0]  s_axis_tdata,   // start_x, start_y, end_x, end_y, color
  input  logic                     s_axis_tuser,   // op: load or step
  // Pixel stream.
  output logic                     m_axis_tvalid,
  input  logic                     m_axis_tready,
  output logic [OUT_DATA_BITS-1:0] m_axis_tdata,   // pixel_x, pixel_y, pixel_color
  output logic                     m_axis_tlast    // last_pixel
);

  bls_cmd_t              front_cmd, head_cmd;
  logic                  head_valid, head_pop;
  logic [COORD_BITS-1:0] pix_x, pix_y;
  logic [COLOR_BITS-1:0] pix_color;

  // Decode the word and compute deltas, step signs, major axis and error setup.
  bls_front u_front (
    .op   (s_axis_tuser),
    .data (s_axis_tdata),
    .cmd  (front_cmd)
  );

  // Hold decoded words so input can run ahead of a stalled pixel sink.
  bls_fifo u_fifo (
    .clk       (clk),
    .rst       (rst),
    .push      (s_axis_tvalid),
    .push_data (front_cmd),
    .in_ready  (s_axis_tready),
    .pop       (head_pop),
    .out_valid (head_valid),
    .out_data  (head_cmd)
  );

  // Advance the active line one pixel per step word; drop steps while idle.
  bls_back u_back (
    .clk       (clk),
    .rst       (rst),
    .cmd_valid (head_valid),
    .cmd       (head_cmd),
    .cmd_pop   (head_pop),
    .out_valid (m_axis_tvalid),
    .out_ready (m_axis_tready),
    .out_x     (pix_x),
    .out_y     (pix_y),
    .out_color (pix_color),
    .out_last  (m_axis_tlast)
  );

  // Pack the pixel, zero-filled up to whole bytes.
  assign m_axis_tdata = OUT_DATA_BITS'({pix_color, pix_y, pix_x});

endmodule
